// ----- rtl/core/shs_pkg.sv -----
`timescale 1ns / 1ps
package shs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RND,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam logic MODE_SHA1   = 1'b0;
  localparam logic MODE_SHA256 = 1'b1;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [6:0] LAST_RND_SHA1   = 7'd79;
  localparam logic [6:0] LAST_RND_SHA256 = 7'd63;
  localparam logic [2:0] LAST_IDX_SHA1   = 3'd4;
  localparam logic [2:0] LAST_IDX_SHA256 = 3'd7;

  typedef logic [31:0] word_t;

  function automatic word_t iv_word(input logic mode, input logic [2:0] idx);
    word_t r;
    r = '0;
    if (mode == MODE_SHA256) begin
      case (idx)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        3'd7: r = 32'h5be0cd19;
        default: r = '0;
      endcase
    end else begin
      case (idx)
        3'd0: r = 32'h67452301;
        3'd1: r = 32'hefcdab89;
        3'd2: r = 32'h98badcfe;
        3'd3: r = 32'h10325476;
        3'd4: r = 32'hc3d2e1f0;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic word_t k_sha1(input logic [6:0] rnd);
    word_t r;
    if (rnd < 7'd20) r = 32'h5a827999;
    else if (rnd < 7'd40) r = 32'h6ed9eba1;
    else if (rnd < 7'd60) r = 32'h8f1bbcdc;
    else r = 32'hca62c1d6;
    return r;
  endfunction

  function automatic word_t k_sha256(input logic [5:0] rnd);
    word_t r;
    case (rnd)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/sha1_sha256_hash_engine_top.sv -----
`timescale 1ns / 1ps
// A non-final word is stored in the message block. When it fills the block, the engine
// runs R rounds (R = 80 for SHA-1, 64 for SHA-256, one round per cycle on the shared
// round unit) and then adds the result into the chaining values. A final word adds pad
// fill (one word per cycle), one or two compressions and then 5 or 8 digest transfers.
// No new input word is accepted until the engine is idle again.
// Reset (rst_ni low, asynchronous): SHA-1 mode, SHA-1 initial values, empty message.
module sha1_sha256_hash_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import shs_pkg::*;

  state_e state_q, state_d;

  logic        mode_q;
  word_t       cv_q [8];
  word_t       v_q  [8];
  word_t       w_q  [16];
  logic [3:0]  fill_q;
  logic [63:0] bytes_q;
  logic [3:0]  ptr_q;
  logic        pad_done_q;
  logic        two_q;
  logic        final_q;
  logic [6:0]  rnd_q;
  logic [2:0]  idx_q;

  logic        in_xfer, out_xfer;
  logic [2:0]  cnt_sat;
  word_t       last_val;
  logic        last_pad;
  logic [4:0]  pad_pos;
  logic [63:0] bytes_last;
  logic [63:0] len_bits;
  word_t       pad_val;
  logic        rnd_end;
  logic [2:0]  idx_end;
  word_t       w_new1, w_new2, wt;
  word_t       f1, t1_1, t1_2, t2_2;
  word_t       s0x, s1y;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  assign rnd_end = (rnd_q == ((mode_q == MODE_SHA256) ? LAST_RND_SHA256 : LAST_RND_SHA1));
  assign idx_end = (mode_q == MODE_SHA256) ? LAST_IDX_SHA256 : LAST_IDX_SHA1;

  always_comb begin
    cnt_sat = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    last_pad = 1'b1;
    case (cnt_sat)
      3'd0: last_val = PAD_WORD;
      3'd1: last_val = {data_word_i[31:24], 8'h80, 16'h0};
      3'd2: last_val = {data_word_i[31:16], 8'h80, 8'h0};
      3'd3: last_val = {data_word_i[31:8], 8'h80};
      default: begin
        last_val = data_word_i;
        last_pad = 1'b0;
      end
    endcase
    pad_pos    = {1'b0, fill_q} + {4'd0, ~last_pad};
    bytes_last = bytes_q + {61'd0, cnt_sat};
  end

  assign len_bits = {bytes_q[60:0], 3'b000};

  always_comb begin
    pad_val = pad_done_q ? '0 : PAD_WORD;
    if (!two_q && ptr_q == 4'd14) pad_val = len_bits[63:32];
    if (!two_q && ptr_q == 4'd15) pad_val = len_bits[31:0];
  end

  // message schedule, oldest word at w_q[0]
  always_comb begin
    w_new1 = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new1 = {w_new1[30:0], w_new1[31]};
    s0x = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1y = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
        ^ (w_q[14] >> 10);
    w_new2 = s1y + w_q[9] + s0x + w_q[0];
    if (rnd_q < 7'd16) wt = w_q[0];
    else wt = (mode_q == MODE_SHA256) ? w_new2 : w_new1;
  end

  always_comb begin
    if (rnd_q < 7'd20) f1 = (v_q[1] & v_q[2]) ^ (~v_q[1] & v_q[3]);
    else if (rnd_q < 7'd40) f1 = v_q[1] ^ v_q[2] ^ v_q[3];
    else if (rnd_q < 7'd60) f1 = (v_q[1] & v_q[2]) ^ (v_q[1] & v_q[3]) ^ (v_q[2] & v_q[3]);
    else f1 = v_q[1] ^ v_q[2] ^ v_q[3];
    t1_1 = {v_q[0][26:0], v_q[0][31:27]} + f1 + v_q[4] + k_sha1(rnd_q) + wt;
    t1_2 = v_q[7]
         + ({v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
            ^ {v_q[4][24:0], v_q[4][31:25]})
         + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + k_sha256(rnd_q[5:0]) + wt;
    t2_2 = ({v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
            ^ {v_q[0][21:0], v_q[0][31:22]})
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (fill_q == 4'd15) state_d = ST_RND;
          else if (is_last_i) state_d = ST_PAD;
        end
      end
      ST_PAD: if (ptr_q == 4'd15) state_d = ST_RND;
      ST_RND: if (rnd_end) state_d = ST_FIN;
      ST_FIN: begin
        if (!final_q) state_d = ST_IDLE;
        else if (two_q) state_d = ST_PAD;
        else state_d = ST_OUT;
      end
      ST_OUT: if (out_xfer && idx_q == idx_end) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) state_d = ST_IDLE;
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    out_valid_o   = (state_q == ST_OUT);
    digest_word_o = cv_q[idx_q];
    word_index_o  = idx_q;
    last_word_o   = (idx_q == idx_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_SHA1;
      fill_q     <= '0;
      bytes_q    <= '0;
      ptr_q      <= '0;
      pad_done_q <= 1'b0;
      two_q      <= 1'b0;
      final_q    <= 1'b0;
      rnd_q      <= '0;
      idx_q      <= '0;
      for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(MODE_SHA1, 3'(i));
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q  <= cfg_wdata_i;
        bytes_q <= '0;
        fill_q  <= '0;
        for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(cfg_wdata_i, 3'(i));
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (in_xfer) begin
              rnd_q <= '0;
              for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
              if (is_last_i) begin
                w_q[fill_q] <= last_val;
                bytes_q     <= bytes_last;
                pad_done_q  <= last_pad;
                two_q       <= (pad_pos >= 5'd14);
                final_q     <= 1'b1;
                ptr_q       <= fill_q + 4'd1;
                fill_q      <= '0;
              end else begin
                w_q[fill_q] <= data_word_i;
                bytes_q     <= bytes_q + 64'd4;
                final_q     <= 1'b0;
                fill_q      <= fill_q + 4'd1;
              end
            end
          end
          ST_PAD: begin
            w_q[ptr_q] <= pad_val;
            pad_done_q <= 1'b1;
            ptr_q      <= ptr_q + 4'd1;
            rnd_q      <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
          end
          ST_RND: begin
            rnd_q <= rnd_q + 7'd1;
            for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
            w_q[15] <= wt;
            if (mode_q == MODE_SHA256) begin
              v_q[0] <= t1_2 + t2_2;
              v_q[1] <= v_q[0];
              v_q[2] <= v_q[1];
              v_q[3] <= v_q[2];
              v_q[4] <= v_q[3] + t1_2;
              v_q[5] <= v_q[4];
              v_q[6] <= v_q[5];
              v_q[7] <= v_q[6];
            end else begin
              v_q[0] <= t1_1;
              v_q[1] <= v_q[0];
              v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
              v_q[3] <= v_q[2];
              v_q[4] <= v_q[3];
            end
          end
          ST_FIN: begin
            for (int i = 0; i < 8; i++) begin
              if (mode_q == MODE_SHA256 || i < 5) cv_q[i] <= cv_q[i] + v_q[i];
            end
            if (final_q && two_q) begin
              two_q <= 1'b0;
              ptr_q <= '0;
            end
            idx_q <= '0;
          end
          ST_OUT: begin
            if (out_xfer) begin
              idx_q <= idx_q + 3'd1;
              if (idx_q == idx_end) begin
                for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(mode_q, 3'(i));
                bytes_q <= '0;
                fill_q  <= '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/shs_checker.sv -----
`timescale 1ns / 1ps
module shs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] word_index_o,
  input logic       last_word_o,
  input logic       cfg_we_i
);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest pending");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_word_o) |-> (word_index_o == 3'd4 || word_index_o == 3'd7))
    else $error("last digest word at bad index");

  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o && !cfg_we_i)
      |=> (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest index did not advance");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (in_ready_o && !out_valid_o))
    else $error("engine not idle after digest");

endmodule

bind sha1_sha256_hash_engine_top shs_checker u_shs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .word_index_o(word_index_o),
  .last_word_o (last_word_o),
  .cfg_we_i    (cfg_we_i)
);
